// File: hdl/ssre_pkg.sv
// shared types, constants and the segment table of the seven-segment refresh encoder
package ssre_pkg;

    localparam int VALUE_W    = 14;
    localparam int PERIOD_W   = 16;
    localparam int BYTE_W     = 8;
    localparam int DIGIT_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int PROD_W     = 28;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 14'd9999;

    // configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BRIGHTNESS     = 2'd0,
        CFG_DISPLAY_ON     = 2'd1,
        CFG_REFRESH_PERIOD = 2'd2
    } cfg_index_t;

    localparam logic [2:0]          BRIGHTNESS_RST = 3'd7;
    localparam logic                DISPLAY_ON_RST = 1'b1;
    localparam logic [PERIOD_W-1:0] PERIOD_RST     = 16'd1000;

    // driver command bytes
    localparam logic [BYTE_W-1:0] CTRL_BASE      = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_AUTO_INC   = 8'h40;
    localparam logic [BYTE_W-1:0] CMD_START_ADDR = 8'hC0;
    localparam logic [BYTE_W-1:0] SEG_BLANK      = 8'h00;

    // reciprocal multipliers, exact for values up to 9999
    localparam logic [VALUE_W-1:0] RECIP_1000 = 14'd8389;
    localparam logic [VALUE_W-1:0] RECIP_100  = 14'd5243;
    localparam logic [15:0]        RECIP_10   = 16'd26215;
    localparam int SHIFT_1000 = 23;
    localparam int SHIFT_100  = 19;
    localparam int SHIFT_10   = 18;

    typedef struct packed {
        logic [DIGIT_W-1:0] thousands;
        logic [DIGIT_W-1:0] hundreds;
        logic [DIGIT_W-1:0] tens;
        logic [DIGIT_W-1:0] ones;
        logic               show_thousands;
        logic               show_hundreds;
        logic               show_tens;
    } digits_t;

    function automatic logic [BYTE_W-1:0] seg_code(input logic [DIGIT_W-1:0] digit);
        logic [BYTE_W-1:0] code;
        case (digit)
            4'd0:    code = 8'h3F;
            4'd1:    code = 8'h06;
            4'd2:    code = 8'h5B;
            4'd3:    code = 8'h4F;
            4'd4:    code = 8'h66;
            4'd5:    code = 8'h6D;
            4'd6:    code = 8'h7D;
            4'd7:    code = 8'h07;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h6F;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

// File: hdl/ssre_front.sv
// input register stage: saturation, change detect and refresh counter
module ssre_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [ssre_pkg::VALUE_W-1:0]  display_value,
    input  logic [ssre_pkg::PERIOD_W-1:0] refresh_period,
    output logic                          req_valid,
    output logic [ssre_pkg::VALUE_W-1:0]  req_value,
    input  logic                          req_take
);
    import ssre_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [VALUE_W-1:0]  value_reg;
    logic [VALUE_W-1:0]  last_shown_reg;
    logic [VALUE_W-1:0]  last_shown_next;
    logic [PERIOD_W-1:0] refresh_count_reg;
    logic [PERIOD_W-1:0] refresh_count_next;
    logic [VALUE_W-1:0]  sat_value;
    logic [PERIOD_W-1:0] base_count;
    logic                accept;
    logic                changed;
    logic                period_hit;
    logic                send;

    assign in_stall  = valid_reg && !req_take;
    assign accept    = in_valid && !in_stall;
    assign req_valid = valid_reg;
    assign req_value = value_reg;

    always_comb
    begin
        sat_value  = (display_value > VALUE_MAX) ? VALUE_MAX : display_value;
        changed    = (sat_value != last_shown_reg);
        base_count = changed ? '0 : refresh_count_reg;
        period_hit = (base_count >= refresh_period);
        send       = changed || period_hit;

        last_shown_next    = last_shown_reg;
        refresh_count_next = refresh_count_reg;
        valid_next         = valid_reg;
        if (accept)
        begin
            last_shown_next    = sat_value;
            refresh_count_next = period_hit ? '0 : base_count + 16'd1;
            valid_next         = send;
        end
        else if (req_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg         <= 1'b0;
            last_shown_reg    <= '0;
            refresh_count_reg <= '0;
        end
        else
        begin
            valid_reg         <= valid_next;
            last_shown_reg    <= last_shown_next;
            refresh_count_reg <= refresh_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && send)
        begin
            value_reg <= sat_value;
        end
    end

endmodule

// File: hdl/ssre_divide.sv
// two-stage binary to decimal digit split by reciprocal multiplication
module ssre_divide (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    input  logic [ssre_pkg::VALUE_W-1:0] req_value,
    output logic                         req_take,
    output logic                         dig_valid,
    output ssre_pkg::digits_t            digits,
    input  logic                         dig_take
);
    import ssre_pkg::*;

    // low four bits of x * 10
    function automatic logic [DIGIT_W-1:0] times10_lo(input logic [DIGIT_W-1:0] x);
        return {x[0], 3'b000} + {x[2:0], 1'b0};
    endfunction

    logic               a_valid_reg;
    logic [VALUE_W-1:0] a_value_reg;
    logic [3:0]         a_q1000_reg;
    logic [6:0]         a_q100_reg;
    logic [9:0]         a_q10_reg;
    logic               b_valid_reg;
    digits_t            b_digits_reg;
    digits_t            b_digits_next;
    logic [PROD_W-1:0]  prod_1000;
    logic [PROD_W-1:0]  prod_100;
    logic [PROD_W-1:0]  prod_10;
    logic               a_free;
    logic               b_free;
    logic               a_move;

    assign b_free    = !b_valid_reg || dig_take;
    assign a_free    = !a_valid_reg || b_free;
    assign req_take  = req_valid && a_free;
    assign a_move    = a_valid_reg && b_free;
    assign dig_valid = b_valid_reg;
    assign digits    = b_digits_reg;

    // quotients by 1000, 100 and 10, each straight from the value
    assign prod_1000 = PROD_W'(req_value) * PROD_W'(RECIP_1000);
    assign prod_100  = PROD_W'(req_value) * PROD_W'(RECIP_100);
    assign prod_10   = PROD_W'(req_value) * PROD_W'(RECIP_10);

    always_comb
    begin
        b_digits_next.thousands      = a_q1000_reg;
        b_digits_next.hundreds       = a_q100_reg[3:0] - times10_lo(a_q1000_reg);
        b_digits_next.tens           = a_q10_reg[3:0] - times10_lo(a_q100_reg[3:0]);
        b_digits_next.ones           = a_value_reg[3:0] - times10_lo(a_q10_reg[3:0]);
        b_digits_next.show_thousands = (a_q1000_reg != '0);
        b_digits_next.show_hundreds  = (a_q100_reg != '0);
        b_digits_next.show_tens      = (a_q10_reg != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
            begin
                a_valid_reg <= req_valid;
            end
            if (b_free)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            a_value_reg <= req_value;
            a_q1000_reg <= prod_1000[SHIFT_1000 +: 4];
            a_q100_reg  <= prod_100[SHIFT_100 +: 7];
            a_q10_reg   <= prod_10[SHIFT_10 +: 10];
        end
        if (a_move)
        begin
            b_digits_reg <= b_digits_next;
        end
    end

endmodule

// File: hdl/ssre_frame.sv
// frame serializer: ten bytes per request into the output register
module ssre_frame (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        dig_valid,
    input  ssre_pkg::digits_t           digits,
    output logic                        dig_take,
    input  logic [ssre_pkg::BYTE_W-1:0] ctrl_byte,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ssre_pkg::BYTE_W-1:0] spi_byte,
    output logic                        last_byte
);
    import ssre_pkg::*;

    localparam logic [3:0] POS_CTRL      = 4'd0;
    localparam logic [3:0] POS_AUTO_INC  = 4'd1;
    localparam logic [3:0] POS_ADDR      = 4'd2;
    localparam logic [3:0] POS_THOUSANDS = 4'd3;
    localparam logic [3:0] POS_PAD_TH    = 4'd4;
    localparam logic [3:0] POS_HUNDREDS  = 4'd5;
    localparam logic [3:0] POS_PAD_HU    = 4'd6;
    localparam logic [3:0] POS_TENS      = 4'd7;
    localparam logic [3:0] POS_PAD_TE    = 4'd8;
    localparam logic [3:0] POS_LAST      = 4'd9;

    logic              busy_reg;
    logic              busy_next;
    logic [3:0]        pos_reg;
    logic [3:0]        pos_next;
    digits_t           frame_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;
    logic [BYTE_W-1:0] byte_sel;
    logic              out_free;
    logic              emit;
    logic              at_last;
    logic              frame_free;

    assign out_free   = !out_valid_reg || !out_stall;
    assign emit       = busy_reg && out_free;
    assign at_last    = (pos_reg == POS_LAST);
    assign frame_free = !busy_reg || (emit && at_last);
    assign dig_take   = dig_valid && frame_free;
    assign out_valid  = out_valid_reg;
    assign spi_byte   = byte_reg;
    assign last_byte  = last_reg;

    always_comb
    begin
        case (pos_reg)
            POS_CTRL:      byte_sel = ctrl_byte;
            POS_AUTO_INC:  byte_sel = CMD_AUTO_INC;
            POS_ADDR:      byte_sel = CMD_START_ADDR;
            POS_THOUSANDS: byte_sel = frame_reg.show_thousands ?
                                      seg_code(frame_reg.thousands) : SEG_BLANK;
            POS_PAD_TH:    byte_sel = SEG_BLANK;
            POS_HUNDREDS:  byte_sel = frame_reg.show_hundreds ?
                                      seg_code(frame_reg.hundreds) : SEG_BLANK;
            POS_PAD_HU:    byte_sel = SEG_BLANK;
            POS_TENS:      byte_sel = frame_reg.show_tens ?
                                      seg_code(frame_reg.tens) : SEG_BLANK;
            POS_PAD_TE:    byte_sel = SEG_BLANK;
            POS_LAST:      byte_sel = seg_code(frame_reg.ones);
            default:       byte_sel = SEG_BLANK;
        endcase
    end

    always_comb
    begin
        busy_next      = busy_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            pos_next = pos_reg + 4'd1;
            if (at_last)
            begin
                busy_next = 1'b0;
            end
        end
        if (dig_take)
        begin
            busy_next = 1'b1;
            pos_next  = POS_CTRL;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pos_reg       <= POS_CTRL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dig_take)
        begin
            frame_reg <= digits;
        end
        if (emit)
        begin
            byte_reg <= byte_sel;
            last_reg <= at_last;
        end
    end

endmodule

// File: hdl/seven_segment_refresh_encoder.sv
// top level of the seven-segment refresh encoder: configuration registers and datapath
//
// input channel: one request per tick carries display_value (0..9999, larger values
//   saturate to 9999); accepted when in_valid is high and in_stall is low
// output channel: spi_byte/last_byte, one frame byte per accepted transfer; a frame is
//   control, 0x40, 0xC0, then three digit/zero pairs and the ones digit, last_byte marks the tenth byte
// a request that neither changes the shown value nor hits the refresh period makes no
//   frame and only bumps the refresh counter
// path: the first byte of a frame passes the input register, two divide stages, the
//   frame register and the output register
// flow: a request without a frame never holds up the next one; a frame leaves byte
//   by byte through the single byte-wide output register; frames follow with no gap
// backpressure: out_stall holds the output byte, the frame serializer and divide stages
//   then fill and in_stall rises; up to five frames sit inside the block: one ending
//   in the output register, one in the serializer, three in input and divide stages
// config: cfg_we writes cfg_data into cfg_index; user writes only while idle, unchecked
// reset: config returns to brightness 7, display on, refresh period 1000; the last
//   shown value and the refresh counter clear, and all pipeline stages empty
module seven_segment_refresh_encoder (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ssre_pkg::VALUE_W-1:0]    display_value,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ssre_pkg::BYTE_W-1:0]     spi_byte,
    output logic                            last_byte,
    input  logic                            cfg_we,
    input  logic [ssre_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssre_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ssre_pkg::*;

    // configuration registers
    logic [2:0]          brightness_reg;
    logic                display_on_reg;
    logic [PERIOD_W-1:0] refresh_period_reg;
    logic [BYTE_W-1:0]   ctrl_byte;

    // request from the input stage into the divider
    logic                req_valid;
    logic [VALUE_W-1:0]  req_value;
    logic                req_take;

    // digits from the divider into the serializer
    logic                dig_valid;
    digits_t             digits;
    logic                dig_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg     <= BRIGHTNESS_RST;
            display_on_reg     <= DISPLAY_ON_RST;
            refresh_period_reg <= PERIOD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BRIGHTNESS:     brightness_reg     <= cfg_data[2:0];
                CFG_DISPLAY_ON:     display_on_reg     <= cfg_data[0];
                CFG_REFRESH_PERIOD: refresh_period_reg <= cfg_data[PERIOD_W-1:0];
                default:            ;  // unmapped index, write ignored
            endcase
        end
    end

    // display control byte: fixed top bit, enable in bit 3, brightness below
    assign ctrl_byte = CTRL_BASE | {4'b0000, display_on_reg, brightness_reg};

    ssre_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .display_value  (display_value),
        .refresh_period (refresh_period_reg),
        .req_valid      (req_valid),
        .req_value      (req_value),
        .req_take       (req_take)
    );

    ssre_divide u_divide (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_value (req_value),
        .req_take  (req_take),
        .dig_valid (dig_valid),
        .digits    (digits),
        .dig_take  (dig_take)
    );

    ssre_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .dig_valid (dig_valid),
        .digits    (digits),
        .dig_take  (dig_take),
        .ctrl_byte (ctrl_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .spi_byte  (spi_byte),
        .last_byte (last_byte)
    );

endmodule

// File: hdl/ssre_checker.sv
// port-level checks of the seven-segment refresh encoder, bound to the top level
module ssre_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [ssre_pkg::BYTE_W-1:0] spi_byte,
    input logic                        last_byte
);
    import ssre_pkg::*;

    // a held byte keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(spi_byte) && $stable(last_byte))
        else $error("output byte changed while stalled");

    // the auto-increment command is followed at once by the start address
    a_addr_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && spi_byte == CMD_AUTO_INC
        |=> out_valid && spi_byte == CMD_START_ADDR)
        else $error("start address did not follow the command byte");

    // the final byte is always a lit ones digit
    a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_byte |-> spi_byte != SEG_BLANK && !spi_byte[7])
        else $error("final byte is not a digit code");

    // a frame that starts right after another one opens with a control byte
    a_ctrl_opens: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && last_byte ##1 out_valid |-> spi_byte[7] && !last_byte)
        else $error("frame does not open with a control byte");

endmodule

bind seven_segment_refresh_encoder ssre_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .spi_byte  (spi_byte),
    .last_byte (last_byte)
);

// File: tb/sv/seven_segment_refresh_encoder_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the seven-segment refresh encoder: directed table, then random phases

module seven_segment_refresh_encoder_tb;
    import ssre_pkg::*;

    localparam int          SETTLE_CYCLES  = 12;    // pipeline depth plus margin before a config write
    localparam int          WATCHDOG_LIMIT = 2000;  // cycles with no accepted request on either side
    localparam int          NUM_PHASES     = 8;
    localparam int          PHASE_ITEMS    = 30;
    localparam int          FRAME_BYTES    = 10;
    localparam logic [13:0] DISPLAY_CAP    = 14'd9999;
    localparam logic [3:0]  CTRL_TOP       = 4'b1000;
    localparam logic [7:0]  AUTO_INC_CMD   = 8'h40;
    localparam logic [7:0]  START_ADDR_CMD = 8'hC0;

    typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

    // one directed row: a tick or a register write; typed rows carry their frame literally
    typedef struct {
        row_kind_t   kind;
        cfg_index_t  reg_index;
        logic [15:0] reg_data;
        logic [13:0] value;
        bit          typed;
        bit          framed;
        logic [79:0] frame;
    } stim_row_t;

    typedef struct {
        logic [7:0] code;
        logic       is_last;
    } frame_byte_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [VALUE_W-1:0]    display_value = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [BYTE_W-1:0]     spi_byte;
    logic                  last_byte;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    seven_segment_refresh_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .display_value (display_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .spi_byte      (spi_byte),
        .last_byte     (last_byte),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor copy of the configuration and the refresh state
    logic [2:0]  cur_brightness = 3'd7;
    logic        cur_display_on = 1'b1;
    logic [15:0] cur_period = 16'd1000;
    logic [13:0] shown_value = '0;
    logic [15:0] ticks_since_frame = '0;

    logic [7:0] segment_of [0:9] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                     8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

    frame_byte_t pending_bytes[$];   // frame bytes still owed by the block
    stim_row_t   directed_rows[$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;       // phase with no gaps and no stalls
    bit          valid_up = 1'b0;    // in_valid is being held high

    // decide whether a tick makes a frame and build it, updating the refresh state
    function automatic bit encode_refresh(input logic [13:0] raw, output logic [79:0] frame);
        logic [13:0] v;
        bit          send;
        logic [7:0]  thou, hund, tens, ones;
        v = (raw > DISPLAY_CAP) ? DISPLAY_CAP : raw;
        send = 1'b0;
        if (v != shown_value)
        begin
            shown_value = v;
            ticks_since_frame = '0;
            send = 1'b1;
        end
        // a change still goes through the period test with a cleared counter
        if (ticks_since_frame >= cur_period)
        begin
            ticks_since_frame = '0;
            send = 1'b1;
        end
        else
        begin
            ticks_since_frame = ticks_since_frame + 16'd1;
        end
        // leading zeros blank, ones digit always lit
        thou = (v >= 14'd1000) ? segment_of[v / 1000] : 8'h00;
        hund = (v >= 14'd100) ? segment_of[(v % 1000) / 100] : 8'h00;
        tens = (v >= 14'd10) ? segment_of[(v % 100) / 10] : 8'h00;
        ones = segment_of[v % 10];
        frame = {CTRL_TOP, cur_display_on, cur_brightness, AUTO_INC_CMD, START_ADDR_CMD,
                 thou, 8'h00, hund, 8'h00, tens, 8'h00, ones};
        return send;
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // random display value: repeats dominate so the refresh counter gets exercised
    function automatic logic [13:0] next_display(input logic [13:0] prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return prev;
        else if (r < 62)
            return 14'($urandom_range(0, 9));
        else if (r < 72)
            return 14'($urandom_range(10, 99));
        else if (r < 80)
            return 14'($urandom_range(100, 999));
        else if (r < 92)
            return 14'($urandom_range(1000, 9999));
        return 14'($urandom_range(10000, 16383));
    endfunction

    task automatic add_tick(input logic [13:0] v);
        directed_rows.push_back('{ROW_TICK, CFG_BRIGHTNESS, 16'd0, v, 1'b0, 1'b0, 80'd0});
    endtask

    task automatic add_typed(input logic [13:0] v, input bit framed, input logic [79:0] frame);
        directed_rows.push_back('{ROW_TICK, CFG_BRIGHTNESS, 16'd0, v, 1'b1, framed, frame});
    endtask

    task automatic add_write(input cfg_index_t idx, input logic [15:0] data);
        directed_rows.push_back('{ROW_WRITE, idx, data, 14'd0, 1'b0, 1'b0, 80'd0});
    endtask

    // present one request, wait for acceptance, then log the frame it owes
    task automatic send_display(input logic [13:0] v, input bit typed, input bit framed,
                                input logic [79:0] typed_frame);
        int          gap;
        bit          sent;
        logic [79:0] frame;
        gap = idle_len();
        if (gap > 0)
        begin
            if (valid_up)
            begin
                in_valid <= 1'b0;
                valid_up = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        valid_up = 1'b1;
        display_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // accepted at this edge; typed rows still advance the predictor state
        sent = encode_refresh(v, frame);
        if (typed)
        begin
            sent = framed;
            frame = typed_frame;
        end
        if (sent)
            for (int k = 0; k < FRAME_BYTES; k++)
                pending_bytes.push_back('{frame[79 - 8 * k -: 8], k == FRAME_BYTES - 1});
    endtask

    // drop valid, wait for every owed byte, then let trailing no-frame requests drain
    task automatic wait_idle();
        if (valid_up)
        begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
        end
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BRIGHTNESS:     cur_brightness = data[2:0];
            CFG_DISPLAY_ON:     cur_display_on = data[0];
            CFG_REFRESH_PERIOD: cur_period = data;
            default:            ;
        endcase
        @(posedge clk);
    endtask

    // output side stalls in bursts, with runs of free flow between them
    initial
    begin
        int hold;
        @(posedge rst_n);
        forever
        begin
            repeat ($urandom_range(1, 12)) @(posedge clk);
            hold = idle_len();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // frame byte checker against the oldest owed byte
    always @(posedge clk)
    begin
        frame_byte_t owed;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte, expected none, actual spi_byte %02h last_byte %0b",
                         $time, spi_byte, last_byte);
                mismatch_count++;
            end
            else
            begin
                owed = pending_bytes.pop_front();
                if (spi_byte !== owed.code)
                begin
                    $display("%0t: spi_byte expected %02h actual %02h",
                             $time, owed.code, spi_byte);
                    mismatch_count++;
                end
                if (last_byte !== owed.is_last)
                begin
                    $display("%0t: last_byte expected %0b actual %0b",
                             $time, owed.is_last, last_byte);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: too long with no request moving on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        logic [13:0] value;
        logic [2:0]  level;
        logic [15:0] period;

        // reset state: same value makes no frame, then extremes and saturation
        add_typed(14'd0, 1'b0, 80'd0);
        add_typed(14'd9999, 1'b1, 80'h8F40C0_6F006F006F00_6F);
        add_typed(14'd16383, 1'b0, 80'd0);   // saturates onto the value already shown
        add_typed(14'd10000, 1'b0, 80'd0);
        add_typed(14'd8, 1'b1, 80'h8F40C0_000000000000_7F);
        add_tick(14'd10);
        add_tick(14'd100);
        add_tick(14'd1000);
        add_tick(14'd1234);
        add_tick(14'd5678);
        add_tick(14'd9012);
        // dim, display off: control byte drops to 0x80
        add_write(CFG_BRIGHTNESS, 16'd0);
        add_write(CFG_DISPLAY_ON, 16'd0);
        add_typed(14'd0, 1'b1, 80'h8040C0_000000000000_3F);
        // zero period: a frame on every tick, change or not
        add_write(CFG_REFRESH_PERIOD, 16'd0);
        add_typed(14'd0, 1'b1, 80'h8040C0_000000000000_3F);
        add_typed(14'd0, 1'b1, 80'h8040C0_000000000000_3F);
        add_typed(14'd5, 1'b1, 80'h8040C0_000000000000_6D);
        // period two: change clears the counter, then one quiet tick before a rewrite
        add_write(CFG_BRIGHTNESS, 16'd5);
        add_write(CFG_DISPLAY_ON, 16'd1);
        add_write(CFG_REFRESH_PERIOD, 16'd2);
        add_tick(14'd7);
        add_tick(14'd7);
        add_tick(14'd7);
        add_write(CFG_REFRESH_PERIOD, 16'hFFFF);
        add_tick(14'd42);
        add_tick(14'd42);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                wait_idle();
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_data);
            end
            else
            begin
                send_display(directed_rows[i].value, directed_rows[i].typed,
                             directed_rows[i].framed, directed_rows[i].frame);
            end
        end

        // random phases, each with its own register setting
        value = 14'd42;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_idle();
            quiet = (phase % 3 == 2);
            if (phase == 0)
            begin
                level = 3'd0;
                period = 16'd0;
            end
            else if (phase == 1)
            begin
                level = 3'd7;
                period = 16'hFFFF;
            end
            else
            begin
                level = 3'($urandom_range(0, 7));
                // short periods keep rewrites frequent, a few wider ones in between
                period = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                     : 16'($urandom_range(1, 6));
            end
            // unused upper bits of the narrow registers carry noise
            write_reg(CFG_BRIGHTNESS, {13'($urandom), level});
            write_reg(CFG_DISPLAY_ON, {15'($urandom), 1'(phase != 1)});
            write_reg(CFG_REFRESH_PERIOD, period);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                value = next_display(value);
                send_display(value, 1'b0, 1'b0, 80'd0);
            end
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
